// ----- hw/rtl/srtf_sel_pkg.sv -----
// ----------------------------------------------------------------------------
// srtf_sel_pkg
// Shared types and constants for the three-job shortest-remaining-time
// selector: request and result layouts, action codes and reset lengths.
// ----------------------------------------------------------------------------
package srtf_sel_pkg;

  localparam int unsigned NUM_JOBS  = 3;
  localparam int unsigned JOB_W     = 2;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned OUT_TIME_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Job code that means no job is running or selected.
  localparam logic [JOB_W-1:0] NO_JOB = 2'd3;

  // Action codes carried by a request.
  localparam logic ACT_CONSUME  = 1'b0;
  localparam logic ACT_EVALUATE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_JOB0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_JOB1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_JOB2 = 2'd2;

  // Reload lengths after reset.
  localparam logic [LEN_W-1:0] RESET_LENGTH_JOB0 = 32'd48000;
  localparam logic [LEN_W-1:0] RESET_LENGTH_JOB1 = 32'd20000;
  localparam logic [LEN_W-1:0] RESET_LENGTH_JOB2 = 32'd26000;

  typedef logic [NUM_JOBS-1:0][LEN_W-1:0] len_array_t;

  // One request as taken from the input channel.
  typedef struct packed {
    logic             action;
    logic [JOB_W-1:0] job_id;
    logic [31:0]      tick_count;
  } item_t;

  // One result as shown on the output channel.
  typedef struct packed {
    logic [OUT_TIME_W-1:0] remaining_after;
    logic                  chosen_valid;
    logic [JOB_W-1:0]      chosen_job;
    logic [JOB_W-1:0]      previous_job;
    logic                  switched;
    logic [NUM_JOBS-1:0]   reloaded_mask;
  } result_t;

endpackage

// ----- hw/rtl/srtf_three_task_selector.sv -----
// ----------------------------------------------------------------------------
// srtf_three_task_selector
// Shortest-remaining-time-first selector for three jobs.
// ----------------------------------------------------------------------------
// A request either consumes ticks from one job (saturating at zero) or
// evaluates: jobs at zero are reloaded from their configured lengths and the
// job with the strictly smallest remaining time below all-ones is chosen,
// ties going to the lower index. Each request yields one result. The block
// takes one request per clock while the output is not stalled; a request is
// held in the input register and its result in the result register, around
// the combinational subtract and three-way compare. The user must write
// lengths only while the block is idle; the block itself does not enforce
// this.
// ----------------------------------------------------------------------------
module srtf_three_task_selector import srtf_sel_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LEN_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [JOB_W-1:0]      job_id,
  input  logic [31:0]           tick_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_TIME_W-1:0] remaining_after,
  output logic                  chosen_valid,
  output logic [JOB_W-1:0]      chosen_job,
  output logic [JOB_W-1:0]      previous_job,
  output logic                  switched,
  output logic [NUM_JOBS-1:0]   reloaded_mask
);

  len_array_t lengths;
  item_t      in_item;
  item_t      item;
  logic       item_valid;
  logic       take;
  result_t    result;

  assign in_item.action     = action;
  assign in_item.job_id     = job_id;
  assign in_item.tick_count = tick_count;

  srtf_sel_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lengths   (lengths)
  );

  srtf_sel_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  srtf_sel_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .lengths    (lengths),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign remaining_after = result.remaining_after;
  assign chosen_valid    = result.chosen_valid;
  assign chosen_job      = result.chosen_job;
  assign previous_job    = result.previous_job;
  assign switched        = result.switched;
  assign reloaded_mask   = result.reloaded_mask;

endmodule

// ----- hw/rtl/srtf_sel_regs.sv -----
// ----------------------------------------------------------------------------
// srtf_sel_regs
// Configuration register file holding the reload length of each job.
// ----------------------------------------------------------------------------
module srtf_sel_regs import srtf_sel_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data,
  output len_array_t           lengths
);

  // Writes to an index past the last job are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      lengths[0] <= RESET_LENGTH_JOB0;
      lengths[1] <= RESET_LENGTH_JOB1;
      lengths[2] <= RESET_LENGTH_JOB2;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LENGTH_JOB0: lengths[0] <= cfg_data;
        REG_LENGTH_JOB1: lengths[1] <= cfg_data;
        REG_LENGTH_JOB2: lengths[2] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/srtf_sel_in_stage.sv -----
// ----------------------------------------------------------------------------
// srtf_sel_in_stage
// Input register: captures one request and holds it until the selection
// engine takes it.
// ----------------------------------------------------------------------------
module srtf_sel_in_stage import srtf_sel_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  item_valid,
  output item_t item
);

  // The register frees up in the same cycle that the engine takes it.
  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ----- hw/rtl/srtf_sel_engine.sv -----
// ----------------------------------------------------------------------------
// srtf_sel_engine
// Holds the remaining time of each job and the running job. Applies one
// request (consume or evaluate) per cycle unless stalled; registers results.
// ----------------------------------------------------------------------------
module srtf_sel_engine import srtf_sel_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  len_array_t lengths,
  input  logic       item_valid,
  input  item_t      item,
  output logic       take,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    result
);

  // Compare width covers both the tick count and the time width.
  localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [NUM_JOBS-1:0][TIME_BITS-1:0] remaining;
  logic [NUM_JOBS-1:0][TIME_BITS-1:0] remaining_next;
  logic [JOB_W-1:0]                   running_job;
  logic [JOB_W-1:0]                   running_job_next;
  result_t                            result_next;

  logic [NUM_JOBS-1:0][TIME_BITS-1:0] len_cut;
  logic [NUM_JOBS-1:0][TIME_BITS-1:0] reset_len;
  logic [NUM_JOBS-1:0][TIME_BITS-1:0] refilled;
  logic [NUM_JOBS-1:0]                reload;
  logic [TIME_BITS-1:0]               cur;
  logic [CW-1:0]                      cur_ext;
  logic [CW-1:0]                      ticks_ext;
  logic [TIME_BITS-1:0]               consumed;
  logic                               job_ok;
  logic [TIME_BITS-1:0]               best;
  logic [JOB_W-1:0]                   chosen;
  logic [TIME_BITS-1:0]               cons_out;

  assign take = item_valid && (!out_valid || out_ready);

  // Lengths cut or widened to the time width.
  assign reset_len[0] = TIME_BITS'(CW'(RESET_LENGTH_JOB0));
  assign reset_len[1] = TIME_BITS'(CW'(RESET_LENGTH_JOB1));
  assign reset_len[2] = TIME_BITS'(CW'(RESET_LENGTH_JOB2));

  always_comb begin
    for (int i = 0; i < NUM_JOBS; i++) begin
      len_cut[i]  = TIME_BITS'(CW'(lengths[i]));
      reload[i]   = (remaining[i] == '0);
      refilled[i] = reload[i] ? len_cut[i] : remaining[i];
    end
  end

  // Saturating subtract for a consume request.
  always_comb begin
    job_ok    = (item.job_id != NO_JOB);
    cur       = remaining[job_ok ? item.job_id : JOB_W'(0)];
    cur_ext   = CW'(cur);
    ticks_ext = CW'(item.tick_count);
    consumed  = (cur_ext >= ticks_ext) ? TIME_BITS'(cur_ext - ticks_ext) : '0;
    cons_out  = job_ok ? consumed : '0;
  end

  // Strict minimum below all-ones; ties keep the lower index.
  always_comb begin
    best   = '1;
    chosen = NO_JOB;
    for (int i = 0; i < NUM_JOBS; i++) begin
      if (refilled[i] < best) begin
        best   = refilled[i];
        chosen = JOB_W'(i);
      end
    end
  end

  // Next state and result for the request being taken.
  always_comb begin
    remaining_next   = remaining;
    running_job_next = running_job;
    result_next      = '0;
    unique case (item.action)
      ACT_CONSUME: begin
        if (job_ok) begin
          remaining_next[item.job_id] = consumed;
        end
        result_next.remaining_after = OUT_TIME_W'(CW'(cons_out));
        result_next.chosen_job      = running_job;
        result_next.previous_job    = running_job;
      end
      ACT_EVALUATE: begin
        remaining_next              = refilled;
        running_job_next            = chosen;
        result_next.remaining_after =
          (chosen == NO_JOB) ? '0 : OUT_TIME_W'(CW'(best));
        result_next.chosen_valid    = (chosen != NO_JOB);
        result_next.chosen_job      = chosen;
        result_next.previous_job    = running_job;
        result_next.switched        = (chosen != running_job);
        result_next.reloaded_mask   = reload;
      end
      default: ;
    endcase
  end

  // Job state.
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining   <= reset_len;
      running_job <= NO_JOB;
    end else if (take) begin
      remaining   <= remaining_next;
      running_job <= running_job_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

endmodule

// ----- hw/rtl/srtf_sel_checker.sv -----
// ----------------------------------------------------------------------------
// srtf_sel_checker
// Port-level checks for the selector, bound to the top level.
// ----------------------------------------------------------------------------
module srtf_sel_checker import srtf_sel_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [OUT_TIME_W-1:0] remaining_after,
  input logic                  chosen_valid,
  input logic [JOB_W-1:0]      chosen_job,
  input logic [JOB_W-1:0]      previous_job,
  input logic                  switched,
  input logic [NUM_JOBS-1:0]   reloaded_mask
);

  // No result is shown right after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A valid selection always names a real job.
  a_chosen_real: assert property (@(posedge clk) disable iff (rst)
    (out_valid && chosen_valid) |-> (chosen_job != NO_JOB))
    else $error("chosen_valid with no job");

  // The switch flag matches the old and new job.
  a_switch_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (switched == (chosen_job != previous_job)))
    else $error("switched disagrees with jobs");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(remaining_after)
      && $stable(chosen_job) && $stable(reloaded_mask)))
    else $error("stalled result changed");

endmodule

bind srtf_three_task_selector srtf_sel_checker u_checker (.*);
